FILE: design/hotkey_chord_matcher_core_assert.svh
// assertion macros for the chord matcher
`ifndef HOTKEY_CHORD_MATCHER_CORE_ASSERT_SVH
`define HOTKEY_CHORD_MATCHER_CORE_ASSERT_SVH

// same-cycle implication
`define HCM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HCM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/hcm_pkg.sv
`timescale 1ns / 1ps

package hcm_pkg;

   localparam int KEY_COUNT     = 64;
   localparam int NUM_ACTIONS   = 8;
   localparam int BINDING_REGS  = 8;
   localparam int CODE_W        = 6;
   localparam int CHORD_W       = 64;
   localparam int ACTIONS_W     = 8;
   localparam int DATA_W        = 64;
   localparam int CSR_IDX_W     = $clog2(BINDING_REGS);
   localparam int KEY_IDX_W     = $clog2(KEY_COUNT);

   localparam logic [CHORD_W-1:0] KEY_MASK =
      (KEY_COUNT >= CHORD_W) ? {CHORD_W{1'b1}}
                             : ((CHORD_W'(1) << KEY_COUNT) - CHORD_W'(1));
   localparam logic [CHORD_W-1:0] REAL_MASK = KEY_MASK & ~CHORD_W'(1);

   typedef enum logic [1:0] {
      OP_KEY    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_RECORD = 2'd2
   } hcm_op_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CODE_W-1:0] key_code;
      logic [CODE_W-1:0] logical_code;
      logic              pressed;
   } hcm_req_type;

   typedef struct packed {
      logic [ACTIONS_W-1:0] actions;
      logic                 recording_active;
      logic [CHORD_W-1:0]   recorded_chord;
      logic                 waiting_release;
   } hcm_rsp_type;

   typedef struct packed {
      logic              apply;
      logic [CODE_W-1:0] key;
      logic [CODE_W-1:0] lc;
      logic              down;
   } hcm_key_evt_type;

endpackage

FILE: design/hcm_keymap.sv
`timescale 1ns / 1ps

module hcm_keymap (
   input  logic                          clock,
   input  logic                          reset,
   input  hcm_pkg::hcm_key_evt_type      evt,
   input  logic                          commit,
   output logic                          was_down,
   output logic [hcm_pkg::CHORD_W-1:0]   held
);
   import hcm_pkg::*;

   logic [KEY_COUNT-1:0] phys_held_ff;
   logic [KEY_COUNT-1:0] phys_held_in;
   logic [CODE_W-1:0]    lc_ff [KEY_COUNT];

   assign was_down = phys_held_ff[evt.key[KEY_IDX_W-1:0]];

   // held set as it stands after this event
   always_comb begin
      logic              hit;
      logic              ph;
      logic [CODE_W-1:0] lcv;
      held         = '0;
      phys_held_in = phys_held_ff;
      for (int i = 1; i < KEY_COUNT; i++) begin
         hit = evt.apply && (evt.key == CODE_W'(i));
         ph  = hit ? evt.down : phys_held_ff[i];
         lcv = hit ? evt.lc : lc_ff[i];
         phys_held_in[i] = ph;
         if (ph && ({1'b0, lcv} < (CODE_W+1)'(KEY_COUNT))) begin
            held[lcv] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phys_held_ff <= '0;
      end else if (commit) begin
         phys_held_ff <= phys_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && evt.apply) begin
         lc_ff[evt.key[KEY_IDX_W-1:0]] <= evt.lc;
      end
   end

endmodule

FILE: design/hotkey_chord_matcher_core.sv
`timescale 1ns / 1ps

// Chord hotkey matcher. Takes one transaction per clock with no gaps while the
// result is taken; rsp_ready low holds the flow. Each result passes through
// one input register and then one result register. The logical held set is
// rebuilt in a single pass by decoding and ORing the logical code of every
// held physical key, so that decode-and-OR plus the eight binding subset
// checks set the clock. The user must write bindings through the csr port
// only while no transaction is in flight; the block does not enforce this.
module hotkey_chord_matcher_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  hcm_pkg::hcm_req_type              req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output hcm_pkg::hcm_rsp_type              rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [hcm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hcm_pkg::DATA_W-1:0]        csr_write_data
);
   import hcm_pkg::*;

`include "hotkey_chord_matcher_core_assert.svh"

   logic                    in_vld_ff;
   hcm_req_type             req_ff;
   logic                    rsp_vld_ff;
   hcm_rsp_type             rsp_ff;
   hcm_rsp_type             rsp_in;
   logic [DATA_W-1:0]       binding_ff [BINDING_REGS];

   logic [NUM_ACTIONS-1:0]  fired_ff, fired_in;
   logic                    wait_ff, wait_in;
   logic                    rec_ff, rec_in;
   logic                    started_ff, started_in;
   logic                    released_ff, released_in;
   logic [CHORD_W-1:0]      captured_ff, captured_in;

   logic                    proc;
   logic                    key_ok;
   logic                    was_down;
   logic [CHORD_W-1:0]      held;
   hcm_key_evt_type         evt;

   assign proc      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || proc;
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   assign key_ok = (req_ff.key_code != '0)
                && ({1'b0, req_ff.key_code} < (CODE_W+1)'(KEY_COUNT));

   assign evt.apply = (req_ff.opcode == OP_KEY) && key_ok;
   assign evt.key   = req_ff.key_code;
   assign evt.lc    = req_ff.logical_code;
   assign evt.down  = req_ff.pressed;

   hcm_keymap u_keymap (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt),
      .commit   (proc),
      .was_down (was_down),
      .held     (held)
   );

   always_comb begin
      logic                 empty;
      logic                 fresh;
      logic [CHORD_W-1:0]   b;
      logic                 match;
      logic [ACTIONS_W-1:0] acts;
      empty       = (held & REAL_MASK) == '0;
      fresh       = req_ff.pressed && !was_down;
      acts        = '0;
      fired_in    = fired_ff;
      wait_in     = wait_ff;
      rec_in      = rec_ff;
      started_in  = started_ff;
      released_in = released_ff;
      captured_in = captured_ff;
      case (req_ff.opcode)
         OP_KEY: begin
            if (!key_ok) begin
               // ignored key
            end else if (wait_ff) begin
               if (empty) begin
                  wait_in = 1'b0;
               end
            end else if (rec_ff) begin
               if (fresh && !released_ff) begin
                  started_in  = 1'b1;
                  captured_in = held;
               end
               if (!req_ff.pressed && was_down && started_ff) begin
                  released_in = 1'b1;
               end
               if (released_in && empty) begin
                  rec_in = 1'b0;
               end
            end else begin
               for (int i = 0; i < NUM_ACTIONS; i++) begin
                  b     = binding_ff[i] & REAL_MASK;
                  match = (b != '0) && ((b & ~held) == '0);
                  if (!match) begin
                     fired_in[i] = 1'b0;
                  end else if (fresh && !fired_ff[i]) begin
                     fired_in[i] = 1'b1;
                     acts[i]     = 1'b1;
                  end
               end
            end
         end
         OP_CANCEL: begin
            rec_in   = 1'b0;
            wait_in  = !empty;
            fired_in = '0;
         end
         OP_RECORD: begin
            rec_in      = 1'b1;
            wait_in     = !empty;
            fired_in    = '0;
            started_in  = 1'b0;
            released_in = 1'b0;
            captured_in = '0;
         end
         default: begin
         end
      endcase
      rsp_in.actions          = acts;
      rsp_in.recording_active = rec_in;
      rsp_in.recorded_chord   = captured_in;
      rsp_in.waiting_release  = wait_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         fired_ff    <= '0;
         wait_ff     <= 1'b0;
         rec_ff      <= 1'b0;
         started_ff  <= 1'b0;
         released_ff <= 1'b0;
         captured_ff <= '0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (proc) begin
            rsp_vld_ff  <= 1'b1;
            fired_ff    <= fired_in;
            wait_ff     <= wait_in;
            rec_ff      <= rec_in;
            started_ff  <= started_in;
            released_ff <= released_in;
            captured_ff <= captured_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      if (proc) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BINDING_REGS; i++) begin
            binding_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         for (int i = 0; i < BINDING_REGS; i++) begin
            if (csr_index == CSR_IDX_W'(i)) begin
               binding_ff[i] <= csr_write_data;
            end
         end
      end
   end

   `HCM_ASSERT_NEXT(a_no_actions_off_key, proc && (req_ff.opcode != OP_KEY), rsp_ff.actions == '0, "actions reported for a non-key transaction")
   `HCM_ASSERT_NEXT(a_actions_latched, proc, (rsp_ff.actions & ~ACTIONS_W'(fired_ff)) == '0, "action fired without setting its latch")
   `HCM_ASSERT_NEXT(a_quiet_while_waiting, proc && wait_ff, rsp_ff.actions == '0, "action fired while waiting for release")
   `HCM_ASSERT_NOW(a_result_mirrors_state, rsp_vld_ff && (rsp_ff.recording_active != rec_ff), in_vld_ff, "result flag disagrees with state")

endmodule

FILE: dv/chord_result_checker.sv
`timescale 1ns / 1ps

module chord_result_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  hcm_pkg::hcm_req_type          req_payload,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  hcm_pkg::hcm_rsp_type          rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [hcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hcm_pkg::DATA_W-1:0]    csr_write_data,
   output int                            fail_count,
   output int                            pending,
   output int                            checked,
   output int                            fired_seen
);
   import hcm_pkg::*;

   logic [CHORD_W-1:0]   key_sets [BINDING_REGS];
   logic [KEY_COUNT-1:0] phys_down;
   logic [CODE_W-1:0]    code_of_key [KEY_COUNT];
   logic [ACTIONS_W-1:0] latched;
   logic                 draining;
   logic                 recording;
   logic                 rec_started;
   logic                 rec_released;
   logic [CHORD_W-1:0]   captured;
   hcm_rsp_type          expected_results [$];
   int                   bad = 0;
   int                   compared = 0;
   int                   fired_total = 0;

   function automatic logic [CHORD_W-1:0] logical_held_set();
      logic [CHORD_W-1:0] acc;
      acc = '0;
      for (int k = 1; k < KEY_COUNT; k++)
         if (phys_down[k] && code_of_key[k] < KEY_COUNT) acc[code_of_key[k]] = 1'b1;
      return acc;
   endfunction

   function automatic void drop_chord();
      recording = 1'b0;
      draining  = (logical_held_set() & REAL_MASK) != '0;
      latched   = '0;
   endfunction

   function automatic hcm_rsp_type predict_chord_result(hcm_req_type item);
      hcm_rsp_type        res;
      logic [CHORD_W-1:0] held;
      logic [CHORD_W-1:0] need;
      logic               was_down;
      logic               fresh;
      res = '0;
      case (item.opcode)
         OP_KEY: begin
            if (item.key_code != '0 && item.key_code < KEY_COUNT) begin
               was_down = phys_down[item.key_code];
               phys_down[item.key_code] = item.pressed;
               code_of_key[item.key_code] = item.logical_code;
               held = logical_held_set();
               fresh = item.pressed && !was_down;
               if (draining) begin
                  if ((held & REAL_MASK) == '0) draining = 1'b0;
               end else if (recording) begin
                  if (fresh && !rec_released) begin
                     rec_started = 1'b1;
                     captured = held;
                  end
                  if (!item.pressed && was_down && rec_started) rec_released = 1'b1;
                  if (rec_released && (held & REAL_MASK) == '0) recording = 1'b0;
               end else begin
                  for (int a = 0; a < NUM_ACTIONS; a++) begin
                     need = key_sets[a] & REAL_MASK;
                     if (need == '0 || (need & ~held) != '0) begin
                        latched[a] = 1'b0;
                     end else if (fresh && !latched[a]) begin
                        latched[a] = 1'b1;
                        res.actions[a] = 1'b1;
                     end
                  end
               end
            end
         end
         OP_CANCEL: drop_chord();
         OP_RECORD: begin
            drop_chord();
            recording = 1'b1;
            rec_started = 1'b0;
            rec_released = 1'b0;
            captured = '0;
         end
         default: ;
      endcase
      res.recording_active = recording;
      res.recorded_chord = captured;
      res.waiting_release = draining;
      return res;
   endfunction

   always @(posedge clock) begin
      hcm_rsp_type want;
      if (reset) begin
         for (int r = 0; r < BINDING_REGS; r++) key_sets[r] = '0;
         phys_down = '0;
         latched = '0;
         draining = 1'b0;
         recording = 1'b0;
         rec_started = 1'b0;
         rec_released = 1'b0;
         captured = '0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               bad++;
               if (bad <= 10) $display("unexpected result %h with no transaction outstanding",
                                       rsp_payload);
            end else begin
               want = expected_results.pop_front();
               compared++;
               if (want.actions != '0) fired_total++;
               if (rsp_payload.actions !== want.actions ||
                   rsp_payload.recording_active !== want.recording_active ||
                   rsp_payload.recorded_chord !== want.recorded_chord ||
                   rsp_payload.waiting_release !== want.waiting_release) begin
                  bad++;
                  if (bad <= 10) begin
                     $display("result %0d mismatch (expected / actual):", compared);
                     $display("   actions %h / %h, recording_active %b / %b",
                              want.actions, rsp_payload.actions,
                              want.recording_active, rsp_payload.recording_active);
                     $display("   recorded_chord %h / %h, waiting_release %b / %b",
                              want.recorded_chord, rsp_payload.recorded_chord,
                              want.waiting_release, rsp_payload.waiting_release);
                  end
               end
            end
         end
         if (csr_write_enable && csr_index < BINDING_REGS) key_sets[csr_index] = csr_write_data;
         if (req_valid && req_ready)
            expected_results.push_back(predict_chord_result(req_payload));
      end
      fail_count <= bad;
      pending    <= expected_results.size();
      checked    <= compared;
      fired_seen <= fired_total;
   end

endmodule

FILE: dv/hotkey_chord_matcher_core_tb.sv
`timescale 1ns / 1ps

module hotkey_chord_matcher_core_tb;
   import hcm_pkg::*;

   localparam logic [1:0] OP_SPARE      = 2'd3;
   localparam int         STALL_LIMIT   = 1000;
   localparam int         PHASE_ITEMS   = 260;
   localparam int         RANDOM_PHASES = 5;
   localparam int         QUIET_PHASE   = 3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   hcm_req_type          req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   hcm_rsp_type          rsp_payload;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_write_data = '0;
   logic                 quiet = 1'b0;
   int                   fail_count;
   int                   pending;
   int                   checked;
   int                   fired_seen;
   int                   sent = 0;
   int                   setups = 0;
   int                   idle_run = 0;
   logic [KEY_COUNT-1:0] down_keys = '0;
   logic [CHORD_W-1:0]   key_set_plan [BINDING_REGS];

   hotkey_chord_matcher_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   chord_result_checker result_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .checked          (checked),
      .fired_seen       (fired_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 14);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
         idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   function automatic int key_lc(int k);
      if ($urandom_range(0, 19) == 0) return $urandom_range(0, 63);
      return (k % 6) + 1;
   endfunction

   function automatic logic [CHORD_W-1:0] pick_key_set();
      logic [CHORD_W-1:0] acc;
      int                 roll;
      acc = '0;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         acc = '0;
      end else if (roll < 20) begin
         acc = '1;
      end else if (roll < 30) begin
         acc = {$urandom(), $urandom()};
      end else begin
         for (int j = $urandom_range(0, 2); j >= 0; j--) acc[$urandom_range(1, 6)] = 1'b1;
         if ($urandom_range(0, 9) == 0) acc[0] = 1'b1;
      end
      return acc;
   endfunction

   task automatic load_key_sets();
      for (int r = 0; r < BINDING_REGS; r++) begin
         csr_write_enable <= 1'b1;
         csr_index <= CSR_IDX_W'(r);
         csr_write_data <= key_set_plan[r];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      setups++;
   endtask

   task automatic send_item(input hcm_req_type item);
      while (!quiet && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.opcode == OP_KEY && item.key_code != '0) down_keys[item.key_code] = item.pressed;
      sent++;
   endtask

   task automatic send_key(input int k, input int lc, input logic down);
      hcm_req_type item;
      item.opcode = OP_KEY;
      item.key_code = CODE_W'(k);
      item.logical_code = CODE_W'(lc);
      item.pressed = down;
      send_item(item);
   endtask

   task automatic send_op(input logic [1:0] op);
      hcm_req_type item;
      item.opcode = op;
      item.key_code = CODE_W'($urandom_range(0, 63));
      item.logical_code = CODE_W'($urandom_range(0, 63));
      item.pressed = 1'($urandom_range(0, 1));
      send_item(item);
   endtask

   task automatic release_all();
      for (int k = 1; k < KEY_COUNT; k++)
         if (down_keys[k]) send_key(k, key_lc(k), 1'b0);
   endtask

   // press a few keys, optionally cancel while held, release in rotated order
   task automatic play_chord(input logic cut);
      int keys [4];
      int n;
      int first;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         keys[i] = $urandom_range(1, 12);
         send_key(keys[i], key_lc(keys[i]), 1'b1);
      end
      if (cut) send_op(OP_CANCEL);
      first = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) send_key(keys[(first + i) % n], key_lc(keys[(first + i) % n]), 1'b0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int goal;
      int pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      key_set_plan[0] = 64'h6;
      key_set_plan[1] = 64'h4;
      key_set_plan[2] = '1;
      key_set_plan[3] = 64'h1;
      key_set_plan[4] = 64'h8000_0000_0000_0002;
      key_set_plan[5] = '0;
      key_set_plan[6] = 64'h8;
      key_set_plan[7] = 64'hE;
      load_key_sets();

      send_key(0, 5, 1'b1);
      send_op(OP_SPARE);
      send_key(1, 1, 1'b1);
      send_key(2, 2, 1'b1);
      send_key(2, 2, 1'b1);
      send_key(63, 63, 1'b1);
      send_key(3, 0, 1'b1);
      send_key(2, 2, 1'b0);
      send_key(4, 2, 1'b1);
      send_key(5, 3, 1'b1);
      send_op(OP_CANCEL);
      send_key(6, 1, 1'b1);
      send_key(1, 1, 1'b0);
      send_key(63, 63, 1'b0);
      send_key(3, 0, 1'b0);
      send_key(4, 2, 1'b0);
      send_key(5, 3, 1'b0);
      send_key(6, 1, 1'b0);
      send_op(OP_RECORD);
      send_key(7, 0, 1'b1);
      send_key(8, 63, 1'b1);
      send_key(7, 0, 1'b0);
      send_key(8, 63, 1'b0);
      send_op(OP_RECORD);
      send_key(10, 4, 1'b1);
      send_op(OP_CANCEL);
      send_key(10, 4, 1'b0);
      release_all();
      settle();

      for (int p = 1; p <= RANDOM_PHASES; p++) begin
         for (int r = 0; r < BINDING_REGS; r++) key_set_plan[r] = pick_key_set();
         load_key_sets();
         quiet <= (p == QUIET_PHASE);
         goal = sent + PHASE_ITEMS;
         while (sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               play_chord($urandom_range(0, 99) < 8);
            end else if (pick < 70) begin
               send_op(OP_RECORD);
               play_chord($urandom_range(0, 99) < 15);
            end else if (pick < 80) begin
               play_chord(1'b1);
            end else begin
               send_op(2'($urandom_range(0, 3)));
               if ($urandom_range(0, 3) == 0) release_all();
            end
         end
         release_all();
         settle();
      end

      repeat (4) @(posedge clock);
      $display("covered %0d transactions under %0d binding setups: chords, recordings, cancels, noise",
               sent, setups);
      $display("compared %0d results, %0d of them with fired actions", checked, fired_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
